// ----- src/vrs_pkg.sv -----
// ----------------------------------------------------------------------------
// vrs_pkg
// Shared types and codes for the variable record stack: command and status
// codes, the decoded operation that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package vrs_pkg;

    localparam int LEN_W  = 10;   // record length / request field
    localparam int REQ_W  = 7;    // clamped request, up to 64
    localparam int BYTE_W = 8;
    localparam int FREE_W = 11;   // reported free bytes
    localparam int HDR_W  = 32;   // widest header, four bytes

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_PEEK  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_FIRST,
        OP_PUSH_DATA,
        OP_POP,
        OP_PEEK,
        OP_CLEAR
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [LEN_W-1:0]      len;
        logic [REQ_W-1:0]      req;
        logic [BYTE_W-1:0]     data;
    } t_op;

endpackage

// ----- src/variable_record_stack.sv -----
// ----------------------------------------------------------------------------
// variable_record_stack
// Byte store holding variable-length records stacked downward from the top of
// memory, each record above a little-endian length header.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   -------------------------  ------------------------------------
//  command   start / busy               i_cmd i_first i_length i_in_byte
//  result    o_valid (one-cycle strobe) o_status o_out_byte o_byte_valid
//                                       o_last o_record_length o_free_bytes
//
//  Back end steps, after the front register and queue: a push data byte, a
//  refused push, a clear and an empty pop/peek finish in the idle state. Push
//  of a new record writes the header and then, when the length is not zero,
//  the first data byte, through the single memory write port one byte per
//  cycle. Pop/peek reads the header, waits, computes the count, then reads the
//  data bytes when any are returned; one read per cycle on the memory read
//  port, first the header then the data.
//  Reset: synchronous, active low; the stack comes up empty. Memory contents
//  are not cleared and need no clearing pass.
//  Stalls: busy rises only when the front register and the two-entry queue
//  are full; results leave as one-cycle strobes and cannot be held off.
// ----------------------------------------------------------------------------
module variable_record_stack import vrs_pkg::*; #(
    parameter int STACK_BYTES  = 1024,
    parameter int HEADER_BYTES = 4,
    parameter int MAX_READ     = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_cmd,
    input  logic              i_first,
    input  logic [LEN_W-1:0]  i_length,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_byte_valid,
    output logic              o_last,
    output logic [LEN_W-1:0]  o_record_length,
    output logic [FREE_W-1:0] o_free_bytes
);

    // front end -> queue
    logic w_f_valid;
    t_op  w_f_op;
    logic w_q_full;

    // queue -> back end
    logic w_q_valid;
    t_op  w_q_op;
    logic w_q_pop;

    // Decode and clamp; one item held while the queue is full.
    vrs_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_first    (i_first),
        .i_length   (i_length),
        .i_in_byte  (i_in_byte),
        .i_q_full   (w_q_full),
        .o_op_valid (w_f_valid),
        .o_op       (w_f_op)
    );

    // Decouples intake from the multi-cycle back end operations.
    vrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_op    (w_f_op),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_op    (w_q_op),
        .i_pop   (w_q_pop)
    );

    // Memory, pointers and result generation.
    vrs_back #(
        .STACK_BYTES  (STACK_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (w_q_valid),
        .i_op            (w_q_op),
        .o_op_pop        (w_q_pop),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_last          (o_last),
        .o_record_length (o_record_length),
        .o_free_bytes    (o_free_bytes)
    );

endmodule

// ----- src/vrs_front.sv -----
// ----------------------------------------------------------------------------
// vrs_front
// Accepts command items, classifies them into operations, clamps read
// requests, and holds one decoded operation until the queue takes it.
// ----------------------------------------------------------------------------
module vrs_front import vrs_pkg::*; #(
    parameter int MAX_READ = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_cmd,
    input  logic              i_first,
    input  logic [LEN_W-1:0]  i_length,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_q_full,
    output logic              o_op_valid,
    output t_op               o_op
);

    logic r_valid;
    t_op  r_op;
    t_op  n_op;
    logic w_accept;

    assign busy       = r_valid && i_q_full;
    assign w_accept   = start && !busy;
    assign o_op_valid = r_valid;
    assign o_op       = r_op;

    always_comb begin
        n_op.len  = i_length;
        n_op.data = i_in_byte;
        if (i_length > LEN_W'(MAX_READ)) begin
            n_op.req = REQ_W'(MAX_READ);
        end else begin
            n_op.req = REQ_W'(i_length);
        end
        case (i_cmd)
            CMD_PUSH:  n_op.kind = i_first ? OP_PUSH_FIRST : OP_PUSH_DATA;
            CMD_POP:   n_op.kind = OP_POP;
            CMD_PEEK:  n_op.kind = OP_PEEK;
            CMD_CLEAR: n_op.kind = OP_CLEAR;
            default:   n_op.kind = OP_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept || (r_valid && i_q_full);
        end
        if (w_accept) begin
            r_op <= n_op;
        end
    end

endmodule

// ----- src/vrs_queue.sv -----
// ----------------------------------------------------------------------------
// vrs_queue
// Two-entry operation queue between the front end and the back end.
// ----------------------------------------------------------------------------
module vrs_queue import vrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_pop
);

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (w_wr) begin
            r_slot[r_wp] <= i_op;
        end
    end

endmodule

// ----- src/vrs_back.sv -----
// ----------------------------------------------------------------------------
// vrs_back
// Executes operations against the byte memory: header writes, data writes,
// header read-back, streamed record reads and top pointer bookkeeping.
// ----------------------------------------------------------------------------
module vrs_back import vrs_pkg::*; #(
    parameter int STACK_BYTES  = 1024,
    parameter int HEADER_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_op_valid,
    input  t_op               i_op,
    output logic              o_op_pop,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_byte_valid,
    output logic              o_last,
    output logic [LEN_W-1:0]  o_record_length,
    output logic [FREE_W-1:0] o_free_bytes
);

    localparam int AW = $clog2(STACK_BYTES);
    localparam int PW = $clog2(STACK_BYTES + 1);
    localparam int XW = PW + 2;   // room for top + header + read offset

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR_WR,
        S_DATA_WR,
        S_HDR_RD,
        S_HDR_WAIT,
        S_CALC,
        S_RD,
        S_RD_WAIT
    } t_state;

    logic [BYTE_W-1:0] mem [STACK_BYTES];

    t_state            r_state;
    logic [PW-1:0]     r_top;
    logic [PW-1:0]     r_write_ptr;
    logic [LEN_W:0]    r_bytes_left;
    logic              r_refusing;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_data;
    logic [1:0]        r_hidx;
    logic              r_is_pop;
    logic [REQ_W-1:0]  r_req;
    logic [HDR_W-1:0]  r_stored;
    logic [XW-1:0]     r_base;
    logic [REQ_W-1:0]  r_i;
    logic [REQ_W-1:0]  r_n;

    logic              r_rd_hdr;
    logic              r_rd_dat;
    logic              r_rd_last;
    logic              r_rd_oob;
    logic [1:0]        r_rd_idx;
    logic [BYTE_W-1:0] r_rdata;

    logic              r_valid;
    logic [1:0]        r_status;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_byte_valid;
    logic              r_last;
    logic [LEN_W-1:0]  r_rlen;
    logic [FREE_W-1:0] r_free;

    logic              w_we;
    logic [XW-1:0]     w_waddr;
    logic [BYTE_W-1:0] w_wdata;
    logic              w_re;
    logic [XW-1:0]     w_raddr;
    logic              w_we_ok;
    logic              w_roob;
    logic [BYTE_W-1:0] w_rbyte;
    logic [HDR_W-1:0]  w_lenx;
    logic [HDR_W-1:0]  w_push_need;
    logic [PW-1:0]     w_new_top;
    logic              w_fits;
    logic [REQ_W-1:0]  w_n;
    logic [HDR_W-1:0]  w_room;
    logic [HDR_W:0]    w_pop_need;
    logic [PW-1:0]     w_pop_top;
    logic [PW-1:0]     w_after_top;
    logic [1:0]        w_hlast;

    assign w_hlast     = 2'(HEADER_BYTES - 1);
    assign w_lenx      = HDR_W'(r_len);
    assign w_push_need = HDR_W'(i_op.len) + HDR_W'(HEADER_BYTES);
    assign w_fits      = !(HDR_W'(r_top) < w_push_need);
    assign w_new_top   = r_top - PW'(w_push_need);
    assign w_rbyte     = r_rd_oob ? '0 : r_rdata;

    // Bytes returned: request clamped by the stored length.
    assign w_n = (HDR_W'(r_req) > r_stored) ? REQ_W'(r_stored) : r_req;

    // Pop release: saturate at an empty stack when the header overruns.
    assign w_room     = HDR_W'(STACK_BYTES) - HDR_W'(r_top);
    assign w_pop_need = {1'b0, r_stored} + (HDR_W + 1)'(HEADER_BYTES);
    always_comb begin
        if ((r_stored > w_room) || (w_pop_need >= {1'b0, w_room})) begin
            w_pop_top = PW'(STACK_BYTES);
        end else begin
            w_pop_top = r_top + PW'(w_pop_need);
        end
        w_after_top = r_is_pop ? w_pop_top : r_top;
    end

    // Memory port control.
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = XW'(r_write_ptr);
        w_wdata  = r_data;
        w_re     = 1'b0;
        w_raddr  = r_base + XW'(r_i);
        o_op_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_op_pop = i_op_valid;
                w_wdata  = i_op.data;
                if (i_op_valid && (i_op.kind == OP_PUSH_DATA) && !r_refusing &&
                    (r_bytes_left != '0)) begin
                    w_we = 1'b1;
                end
            end
            S_HDR_WR: begin
                w_we    = 1'b1;
                w_waddr = XW'(r_top) + XW'(r_hidx);
                w_wdata = w_lenx[{r_hidx, 3'b000} +: BYTE_W];
            end
            S_DATA_WR: begin
                w_we = 1'b1;
            end
            S_HDR_RD: begin
                w_re    = 1'b1;
                w_raddr = XW'(r_top) + XW'(r_hidx);
            end
            S_RD: begin
                w_re = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign w_we_ok = w_we && (w_waddr < XW'(STACK_BYTES));
    assign w_roob  = !(w_raddr < XW'(STACK_BYTES));

    always_ff @(posedge i_clk) begin
        if (w_we_ok) begin
            mem[w_waddr[AW-1:0]] <= w_wdata;
        end
        if (w_re && !w_roob) begin
            r_rdata <= mem[w_raddr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_top        <= PW'(STACK_BYTES);
            r_write_ptr  <= '0;
            r_bytes_left <= '0;
            r_refusing   <= 1'b0;
            r_valid      <= 1'b0;
            r_rd_hdr     <= 1'b0;
            r_rd_dat     <= 1'b0;
        end else begin
            r_valid   <= 1'b0;
            r_rd_hdr  <= (r_state == S_HDR_RD);
            r_rd_dat  <= (r_state == S_RD);
            r_rd_idx  <= r_hidx;
            r_rd_last <= (r_i == r_n - 1'b1);
            r_rd_oob  <= w_roob;

            if (r_rd_hdr) begin
                r_stored[{r_rd_idx, 3'b000} +: BYTE_W] <= w_rbyte;
            end
            if (r_rd_dat) begin
                r_valid      <= 1'b1;
                r_status     <= ST_OK;
                r_out_byte   <= w_rbyte;
                r_byte_valid <= 1'b1;
                r_last       <= r_rd_last;
                r_rlen       <= LEN_W'(r_stored);
                r_free       <= FREE_W'(r_top);
            end

            case (r_state)
                S_IDLE: begin
                    if (i_op_valid) begin
                        r_valid      <= 1'b1;
                        r_status     <= ST_OK;
                        r_out_byte   <= '0;
                        r_byte_valid <= 1'b0;
                        r_last       <= 1'b1;
                        r_rlen       <= '0;
                        r_free       <= FREE_W'(r_top);
                        case (i_op.kind)
                            OP_PUSH_FIRST: begin
                                r_bytes_left <= '0;
                                if (!w_fits) begin
                                    r_refusing <= 1'b1;
                                    r_status   <= ST_FULL;
                                end else begin
                                    r_refusing   <= 1'b0;
                                    r_top        <= w_new_top;
                                    r_write_ptr  <= w_new_top + PW'(HEADER_BYTES);
                                    r_bytes_left <= (LEN_W + 1)'(i_op.len);
                                    r_len        <= i_op.len;
                                    r_data       <= i_op.data;
                                    r_hidx       <= '0;
                                    r_free       <= FREE_W'(w_new_top);
                                    r_state      <= S_HDR_WR;
                                end
                            end
                            OP_PUSH_DATA: begin
                                if (r_refusing) begin
                                    r_status <= ST_FULL;
                                end else if (r_bytes_left != '0) begin
                                    r_write_ptr  <= r_write_ptr + 1'b1;
                                    r_bytes_left <= r_bytes_left - 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                r_refusing   <= 1'b0;
                                r_bytes_left <= '0;
                                r_top        <= PW'(STACK_BYTES);
                                r_free       <= FREE_W'(STACK_BYTES);
                            end
                            default: begin
                                // pop or peek
                                r_refusing   <= 1'b0;
                                r_bytes_left <= '0;
                                if (r_top >= PW'(STACK_BYTES)) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_valid  <= 1'b0;
                                    r_is_pop <= (i_op.kind == OP_POP);
                                    r_req    <= i_op.req;
                                    r_hidx   <= '0;
                                    r_stored <= '0;
                                    r_base   <= XW'(r_top) + XW'(HEADER_BYTES);
                                    r_i      <= '0;
                                    r_state  <= S_HDR_RD;
                                end
                            end
                        endcase
                    end
                end
                S_HDR_WR: begin
                    r_hidx <= r_hidx + 1'b1;
                    if (r_hidx == w_hlast) begin
                        r_state <= (r_bytes_left != '0) ? S_DATA_WR : S_IDLE;
                    end
                end
                S_DATA_WR: begin
                    r_write_ptr  <= r_write_ptr + 1'b1;
                    r_bytes_left <= r_bytes_left - 1'b1;
                    r_state      <= S_IDLE;
                end
                S_HDR_RD: begin
                    r_hidx <= r_hidx + 1'b1;
                    if (r_hidx == w_hlast) begin
                        r_state <= S_HDR_WAIT;
                    end
                end
                S_HDR_WAIT: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_top <= w_after_top;
                    r_n   <= w_n;
                    r_i   <= '0;
                    if (w_n == '0) begin
                        r_valid      <= 1'b1;
                        r_status     <= ST_OK;
                        r_out_byte   <= '0;
                        r_byte_valid <= 1'b0;
                        r_last       <= 1'b1;
                        r_rlen       <= LEN_W'(r_stored);
                        r_free       <= FREE_W'(w_after_top);
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == r_n - 1'b1) begin
                        r_state <= S_RD_WAIT;
                    end
                end
                S_RD_WAIT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_out_byte      = r_out_byte;
    assign o_byte_valid    = r_byte_valid;
    assign o_last          = r_last;
    assign o_record_length = r_rlen;
    assign o_free_bytes    = r_free;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for variable_record_stack. A transaction-level predictor of
// the stack tracks memory, top pointer and the record under intake, and every
// result strobe is checked field by field against the oldest predicted
// result. Directed cases come first, then random record traffic in phases
// with and without sender gaps.
// ----------------------------------------------------------------------------
module tb;
    import vrs_pkg::*;

    localparam int STACK_BYTES  = 1024;
    localparam int HEADER_BYTES = 4;
    localparam int MAX_READ     = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 100;   // longest pop returns MAX_READ bytes after the header
    localparam int MAX_REPORTS  = 10;

    // one predicted result strobe
    typedef struct {
        logic [1:0]        status;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last;
        logic [LEN_W-1:0]  rec_len;
        logic [FREE_W-1:0] free;
    } t_stack_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_cmd = CMD_PUSH;
    logic              i_first = 1'b0;
    logic [LEN_W-1:0]  i_length = '0;
    logic [BYTE_W-1:0] i_in_byte = '0;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_byte_valid;
    logic              o_last;
    logic [LEN_W-1:0]  o_record_length;
    logic [FREE_W-1:0] o_free_bytes;

    // predictor state
    logic [7:0] stack_bytes [STACK_BYTES];
    bit         byte_written [STACK_BYTES];   // never-written entries must not be read
    int         top_ptr;
    int         fill_ptr;
    int         fill_left;
    bit         refusing;

    t_stack_result pending_results[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            items_sent = 0;
    int            gap_pct = 0;               // chance per cycle of a sender gap

    variable_record_stack #(
        .STACK_BYTES  (STACK_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_READ     (MAX_READ)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_first         (i_first),
        .i_length        (i_length),
        .i_in_byte       (i_in_byte),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_last          (o_last),
        .o_record_length (o_record_length),
        .o_free_bytes    (o_free_bytes)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic expect_result(input logic [1:0] status, input int data, input bit bv,
                                 input bit last, input int rec_len);
        t_stack_result r;
        r.status     = status;
        r.out_byte   = data[7:0];
        r.byte_valid = bv;
        r.last       = last;
        r.rec_len    = rec_len[LEN_W-1:0];
        r.free       = top_ptr[FREE_W-1:0];
        pending_results.push_back(r);
    endtask

    task automatic store_byte(input int addr, input int data);
        if (addr < STACK_BYTES) begin
            stack_bytes[addr]  = data[7:0];
            byte_written[addr] = 1'b1;
        end
    endtask

    // length header of the record on top, little endian
    function automatic int top_record_len();
        int len;
        len = 0;
        for (int b = 0; b < HEADER_BYTES; b++) begin
            if (top_ptr + b < STACK_BYTES)
                len |= int'(stack_bytes[top_ptr + b]) << (8 * b);
        end
        return len;
    endfunction

    // called at the edge that accepts the item
    task automatic predict_stack_op(input logic [1:0] cmd, input bit first, input int len,
                                    input int data);
        int stored;
        int n;
        int room;
        int need;
        int base;
        int got [$];
        if (cmd == CMD_PUSH) begin
            if (first) begin
                fill_left = 0;
                if (top_ptr < len + HEADER_BYTES) begin
                    refusing = 1'b1;
                    expect_result(ST_FULL, 0, 0, 1, 0);
                end else begin
                    refusing = 1'b0;
                    top_ptr -= len + HEADER_BYTES;
                    for (int b = 0; b < HEADER_BYTES; b++)
                        store_byte(top_ptr + b, (len >> (8 * b)) & 8'hFF);
                    fill_ptr = top_ptr + HEADER_BYTES;
                    if (len > 0) begin
                        store_byte(fill_ptr, data);
                        fill_ptr++;
                        fill_left = len - 1;
                    end
                    expect_result(ST_OK, 0, 0, 1, 0);
                end
            end else if (refusing) begin
                expect_result(ST_FULL, 0, 0, 1, 0);
            end else begin
                // stray byte when nothing is being filled
                if (fill_left > 0) begin
                    store_byte(fill_ptr, data);
                    fill_ptr++;
                    fill_left--;
                end
                expect_result(ST_OK, 0, 0, 1, 0);
            end
        end else begin
            // any other command ends intake of the current record
            fill_left = 0;
            refusing  = 1'b0;
            if (cmd == CMD_CLEAR) begin
                top_ptr = STACK_BYTES;
                expect_result(ST_OK, 0, 0, 1, 0);
            end else if (top_ptr >= STACK_BYTES) begin
                expect_result(ST_EMPTY, 0, 0, 1, 0);
            end else begin
                stored = top_record_len();
                base   = top_ptr + HEADER_BYTES;
                n      = len;
                if (n > MAX_READ) n = MAX_READ;
                if (n > stored)   n = stored;
                for (int i = 0; i < n; i++)
                    got.push_back((base + i < STACK_BYTES) ? int'(stack_bytes[base + i]) : 0);
                if (cmd == CMD_POP) begin
                    room = STACK_BYTES - top_ptr;
                    need = HEADER_BYTES + stored;
                    if (stored > room || need >= room)
                        top_ptr = STACK_BYTES;
                    else
                        top_ptr += need;
                end
                if (n == 0)
                    expect_result(ST_OK, 0, 0, 1, stored);
                for (int i = 0; i < n; i++)
                    expect_result(ST_OK, got[i], 1, i + 1 == n, stored);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: strobes cannot be held off, so every valid is an item
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stack_result e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d byte %0h bv %0b last %0b len %0d free %0d",
                             o_status, o_out_byte, o_byte_valid, o_last, o_record_length,
                             o_free_bytes);
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status || o_out_byte !== e.out_byte
                        || o_byte_valid !== e.byte_valid || o_last !== e.last
                        || o_record_length !== e.rec_len || o_free_bytes !== e.free) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  expected: status %0d byte %0h bv %0b last %0b len %0d free %0d",
                                 e.status, e.out_byte, e.byte_valid, e.last, e.rec_len, e.free);
                        $display("  actual:   status %0d byte %0h bv %0b last %0b len %0d free %0d",
                                 o_status, o_out_byte, o_byte_valid, o_last, o_record_length,
                                 o_free_bytes);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command driver: entered and left at a falling edge, start left high
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] cmd, input bit first, input int len,
                             input int data);
        // each cycle idles with chance gap_pct
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_cmd     <= cmd;
        i_first   <= first;
        i_length  <= len[LEN_W-1:0];
        i_in_byte <= data[7:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_stack_op(cmd, first, len, data);
        @(negedge i_clk);
    endtask

    // first item plus n_send - 1 data bytes; n_send below the length interrupts
    task automatic push_record(input int len, input int n_send);
        for (int k = 0; k < n_send; k++) begin
            send_item(CMD_PUSH, k == 0, len, $urandom_range(255));
            items_sent++;
        end
    endtask

    // keeps a record's push items within the items left in the phase
    function automatic int clip_count(input int n, input int left);
        return (n > left) ? left : n;
    endfunction

    // trims a request so no never-written data byte is read
    function automatic int safe_request(input int req);
        int stored;
        int n;
        int base;
        if (top_ptr >= STACK_BYTES)
            return req;
        stored = top_record_len();
        base   = top_ptr + HEADER_BYTES;
        n      = req;
        if (n > MAX_READ) n = MAX_READ;
        if (n > stored)   n = stored;
        for (int i = 0; i < n; i++) begin
            if (base + i < STACK_BYTES && !byte_written[base + i])
                return i;
        end
        return req;
    endfunction

    function automatic int pick_record_len();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 0;
        if (r < 65) return $urandom_range(1, 8);
        if (r < 90) return $urandom_range(9, 70);
        return $urandom_range(71, 160);
    endfunction

    function automatic int pick_request();
        int r;
        r = $urandom_range(99);
        if (r < 40) return $urandom_range(0, 8);
        if (r < 80) return $urandom_range(0, 70);
        return $urandom_range(0, 1020);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_item(CMD_POP, 0, 1, 0);            // empty stack
        send_item(CMD_PEEK, 1, 1020, 8'hFF);    // empty, first ignored off push
        send_item(CMD_CLEAR, 0, 0, 0);
        send_item(CMD_PUSH, 1, 0, 8'hFF);       // zero length, byte ignored
        send_item(CMD_PEEK, 0, 7, 0);           // record of length zero
        send_item(CMD_PUSH, 1, 3, 8'h00);
        send_item(CMD_PUSH, 0, 0, 8'hFF);
        send_item(CMD_PUSH, 0, 0, 8'hA5);
        send_item(CMD_PUSH, 0, 0, 8'h5A);       // stray byte, ignored
        send_item(CMD_PEEK, 0, 0, 0);           // zero request
        send_item(CMD_PEEK, 0, 1020, 0);        // request far above stored
        send_item(CMD_POP, 0, 2, 0);
        send_item(CMD_POP, 0, 0, 0);            // zero request still frees
        send_item(CMD_PUSH, 1, 1020, 8'h11);    // fills memory exactly
        send_item(CMD_PUSH, 1, 0, 0);           // refused, full
        send_item(CMD_PUSH, 0, 0, 8'h22);       // still refused
        send_item(CMD_PEEK, 0, 0, 0);           // ends refusal
        send_item(CMD_PUSH, 0, 0, 8'h33);       // stray
        send_item(CMD_POP, 0, 1, 0);
        send_item(CMD_CLEAR, 0, 0, 0);
        send_item(CMD_PUSH, 1, 5, 8'h01);
        send_item(CMD_PUSH, 0, 0, 8'h02);
        send_item(CMD_PEEK, 0, 2, 0);           // interrupts intake
        send_item(CMD_CLEAR, 0, 0, 0);
        send_item(CMD_POP, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input int idle, input int n_items);
        int sel;
        int len;
        int stop_at;
        gap_pct = idle;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                len = pick_record_len();
                push_record(len, clip_count((len == 0) ? 1 : len, stop_at - items_sent));
            end else if (sel < 52) begin
                len = pick_record_len();
                push_record(len, clip_count((len <= 1) ? 1 : $urandom_range(1, len - 1),
                                            stop_at - items_sent));
            end else if (sel < 56) begin
                // big reservation, interrupted early: drives the stack full
                push_record($urandom_range(200, 1020),
                            clip_count($urandom_range(1, 4), stop_at - items_sent));
            end else if (sel < 70) begin
                send_item(CMD_POP, $urandom_range(1), safe_request(pick_request()),
                          $urandom_range(255));
                items_sent++;
            end else if (sel < 84) begin
                send_item(CMD_PEEK, $urandom_range(1), safe_request(pick_request()),
                          $urandom_range(255));
                items_sent++;
            end else if (sel < 88) begin
                send_item(CMD_CLEAR, $urandom_range(1), $urandom_range(0, 1020),
                          $urandom_range(255));
                items_sent++;
            end else if (sel < 93) begin
                // loose data byte: stored during intake, refused in a refusal, else ignored
                send_item(CMD_PUSH, 0, $urandom_range(0, 1020), $urandom_range(255));
                items_sent++;
            end else begin
                send_item(CMD_POP, 0, safe_request($urandom_range(65, 1020)), 0);
                items_sent++;
            end
        end
    endtask

    initial begin
        top_ptr   = STACK_BYTES;
        fill_ptr  = 0;
        fill_left = 0;
        refusing  = 1'b0;
        for (int a = 0; a < STACK_BYTES; a++) begin
            stack_bytes[a]  = 8'h00;
            byte_written[a] = 1'b0;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_traffic(0, 110);
        test_random_traffic(55, 110);
        test_random_traffic(34, 105);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
